// ----- hw/rtl/cfvd_pkg.sv -----
// Package for the crossfading delay line: sizes, codes and state type.
package cfvd_pkg;

   // Design sizes.
   localparam int MAX_DELAY   = 4096;
   localparam int SAMPLE_BITS = 24;

   // Derived storage sizes.
   localparam int STORE_SIZE = 2 * MAX_DELAY;
   localparam int ADDR_BITS  = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
   localparam int IDX_BITS   = ADDR_BITS + 1;
   localparam int DELAY_BITS = $clog2(MAX_DELAY + 1);

   // Field widths fixed by the channel format.
   localparam int REQ_DELAY_BITS = 13;
   localparam int FADE_BITS      = 16;

   // Mix ratio in unsigned Q0.16, one extra bit so that 1.0 fits.
   localparam int RATIO_BITS = 17;
   localparam logic [RATIO_BITS-1:0] ONE_Q16 = RATIO_BITS'(65536);
   localparam int ROUND_HALF = 32768;
   localparam int FRAC_BITS  = 16;

   // Shared multiplier operand widths: a holds a tap difference or the ratio.
   localparam int MUL_A_BITS = (SAMPLE_BITS + 1 > RATIO_BITS + 1) ?
                               SAMPLE_BITS + 1 : RATIO_BITS + 1;
   localparam int MUL_B_BITS = RATIO_BITS + 1;
   localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

   // Divider iteration count, one quotient bit a step.
   localparam int DIV_STEPS    = RATIO_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);

   // Request codes.
   localparam logic REQ_SAMPLE    = 1'b0;
   localparam logic REQ_SET_DELAY = 1'b1;

   // Crossfade kinds.
   localparam logic KIND_LINEAR = 1'b0;
   localparam logic KIND_SQUARE = 1'b1;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_RD_NEW,
      ST_RD_OLD,
      ST_MUL_SQ,
      ST_WEIGHT,
      ST_MUL_MIX,
      ST_FINISH,
      ST_SETUP,
      ST_DIV
   } state_type;

endpackage

// ----- hw/rtl/cfvd_if.sv -----
// Request and response channel interfaces of the crossfading delay line.
interface cfvd_req_if import cfvd_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic signed [SAMPLE_BITS-1:0] in_sample;
   logic [REQ_DELAY_BITS-1:0]     new_delay;
   logic                          fade_kind;
   logic [FADE_BITS-1:0]          fade_length;

   modport source (output valid, req_type, in_sample, new_delay, fade_kind, fade_length,
                   input ready);
   modport sink   (input valid, req_type, in_sample, new_delay, fade_kind, fade_length,
                   output ready);
endinterface

interface cfvd_rsp_if import cfvd_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_sample;

   modport source (output valid, out_sample, input ready);
   modport sink   (input valid, out_sample, output ready);
endinterface

// ----- hw/rtl/crossfading_variable_delay_top.sv -----
// Top level of the crossfading variable delay line: sequencer, state and output register.
//
//   Channel  Direction  Carries
//   req_chan in         req_type, in_sample, new_delay, fade_kind, fade_length
//   rsp_chan out        out_sample (one per sample transaction, none for set-delay)
//
// A sample transaction steps from idle through one store write, two reads on the single store
// port, the squaring multiplier pass, a weight step, the mixing multiplier pass and finish,
// where the output register loads. A set-delay transaction goes through setup and, with a
// nonzero fade length, waits on the one-bit-a-cycle divider.
// Reset is synchronous; a write-fill mark makes never-written store entries read as zero.
// The request side is ready only in idle; a finished sample waits while the output is stalled.
module crossfading_variable_delay_top import cfvd_pkg::*; (
   input logic      clock,
   input logic      reset,
   cfvd_req_if.sink   req_chan,
   cfvd_rsp_if.source rsp_chan
);

   state_type state_ff, state_in;

   // Latched request fields.
   logic                          type_ff, type_in;
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic [REQ_DELAY_BITS-1:0]     nd_ff, nd_in;
   logic                          kind_req_ff, kind_req_in;
   logic [FADE_BITS-1:0]          len_ff, len_in;

   // Architectural state.
   logic [ADDR_BITS-1:0]  wr_ff, wr_in;
   logic                  wrapped_ff, wrapped_in;
   logic [DELAY_BITS-1:0] cur_ff, cur_in;
   logic [DELAY_BITS-1:0] old_ff, old_in;
   logic [RATIO_BITS-1:0] ratio_ff, ratio_in;
   logic [RATIO_BITS-1:0] step_ff, step_in;
   logic [FADE_BITS-1:0]  fade_ff, fade_in;
   logic                  kind_ff, kind_in;

   // Datapath registers.
   logic signed [SAMPLE_BITS-1:0] new_s_ff, new_s_in;
   logic signed [SAMPLE_BITS-1:0] old_s_ff, old_s_in;
   logic [RATIO_BITS-1:0]         w_ff, w_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;

   // Store, multiplier and divider connections.
   logic                         st_wr_en;
   logic [ADDR_BITS-1:0]         st_rd_addr;
   logic [SAMPLE_BITS-1:0]       st_rd_data;
   logic signed [MUL_A_BITS-1:0] mul_a;
   logic signed [MUL_B_BITS-1:0] mul_b;
   logic signed [PROD_BITS-1:0]  prod;
   logic                         div_start;
   logic [RATIO_BITS-1:0]        div_dividend;
   logic                         div_done;
   logic [RATIO_BITS-1:0]        div_quotient;

   // Helper values.
   logic [ADDR_BITS-1:0]        idx_new, idx_old;
   logic                        ok_new, ok_old;
   logic                        out_free;
   logic [31:0]                 nd_wide, nd_sat;
   logic [RATIO_BITS-1:0]       ratio_base;
   logic [32:0]                 sq_round;
   logic signed [PROD_BITS-1:0] mix_round, mix_sum;
   logic [RATIO_BITS:0]         ratio_sum;

   // Circular store index of the entry written delay samples earlier.
   function automatic logic [ADDR_BITS-1:0] tap_index(input logic [ADDR_BITS-1:0]  wr,
                                                      input logic [DELAY_BITS-1:0] d);
      logic [IDX_BITS-1:0] sum;
      sum = IDX_BITS'(wr) + IDX_BITS'(STORE_SIZE) - IDX_BITS'(d);
      if (sum >= IDX_BITS'(STORE_SIZE)) begin
         sum = sum - IDX_BITS'(STORE_SIZE);
      end
      return sum[ADDR_BITS-1:0];
   endfunction

   assign idx_new  = tap_index(wr_ff, cur_ff);
   assign idx_old  = tap_index(wr_ff, old_ff);
   // An entry holds a written sample once the index passed it or the store wrapped.
   assign ok_new   = wrapped_ff || (idx_new <= wr_ff);
   assign ok_old   = wrapped_ff || (idx_old <= wr_ff);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Saturated new delay and the ratio a fade restarts from.
   assign nd_wide      = 32'(nd_ff);
   assign nd_sat       = (nd_wide > 32'(MAX_DELAY)) ? 32'(MAX_DELAY) : nd_wide;
   assign ratio_base   = (ratio_ff >= ONE_Q16) ? '0 : ratio_ff;
   assign div_dividend = ONE_Q16 - ratio_base;

   // Rounding of the square weight and of the mixed sample.
   assign sq_round  = prod[32:0] + 33'(ROUND_HALF);
   assign mix_round = prod + PROD_BITS'(ROUND_HALF);
   assign mix_sum   = (mix_round >>> FRAC_BITS) + PROD_BITS'(old_s_ff);
   assign ratio_sum = {1'b0, ratio_ff} + {1'b0, step_ff};

   // Multiplier operands: ratio squared first, then weight times tap difference.
   always_comb begin
      if (state_ff == ST_MUL_SQ) begin
         mul_a = MUL_A_BITS'(ratio_ff);
         mul_b = MUL_B_BITS'(ratio_ff);
      end else begin
         mul_a = MUL_A_BITS'(new_s_ff) - MUL_A_BITS'(old_s_ff);
         mul_b = MUL_B_BITS'(w_ff);
      end
   end

   // Sequencer: next state and register updates.
   always_comb begin
      state_in      = state_ff;
      type_in       = type_ff;
      x_in          = x_ff;
      nd_in         = nd_ff;
      kind_req_in   = kind_req_ff;
      len_in        = len_ff;
      wr_in         = wr_ff;
      wrapped_in    = wrapped_ff;
      cur_in        = cur_ff;
      old_in        = old_ff;
      ratio_in      = ratio_ff;
      step_in       = step_ff;
      fade_in       = fade_ff;
      kind_in       = kind_ff;
      new_s_in      = new_s_ff;
      old_s_in      = old_s_ff;
      w_in          = w_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_sample_in = rsp_sample_ff;
      st_wr_en      = 1'b0;
      st_rd_addr    = idx_new;
      div_start     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               type_in     = req_chan.req_type;
               x_in        = req_chan.in_sample;
               nd_in       = req_chan.new_delay;
               kind_req_in = req_chan.fade_kind;
               len_in      = req_chan.fade_length;
               state_in    = (req_chan.req_type == REQ_SET_DELAY) ? ST_SETUP : ST_WRITE;
            end
         end
         ST_WRITE: begin
            st_wr_en = 1'b1;
            state_in = ST_RD_NEW;
         end
         ST_RD_NEW: begin
            st_rd_addr = idx_new;
            state_in   = ST_RD_OLD;
         end
         ST_RD_OLD: begin
            st_rd_addr = idx_old;
            new_s_in   = ok_new ? $signed(st_rd_data) : '0;
            state_in   = ST_MUL_SQ;
         end
         ST_MUL_SQ: begin
            old_s_in = ok_old ? $signed(st_rd_data) : '0;
            state_in = ST_WEIGHT;
         end
         // The squared ratio is ready, so the weight can be chosen.
         ST_WEIGHT: begin
            w_in     = (kind_ff == KIND_SQUARE) ? sq_round[32:FRAC_BITS] : ratio_ff;
            state_in = ST_MUL_MIX;
         end
         ST_MUL_MIX: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = (fade_ff == '0) ? new_s_ff : SAMPLE_BITS'(mix_sum);
               // Advance the fade; its last step lands exactly on 1.0.
               if (fade_ff != '0) begin
                  ratio_in = (ratio_sum > {1'b0, ONE_Q16}) ? ONE_Q16 :
                             ratio_sum[RATIO_BITS-1:0];
                  fade_in  = fade_ff - 1'b1;
                  if (fade_ff == FADE_BITS'(1)) begin
                     ratio_in = ONE_Q16;
                  end
               end
               if (wr_ff == ADDR_BITS'(STORE_SIZE - 1)) begin
                  wr_in      = '0;
                  wrapped_in = 1'b1;
               end else begin
                  wr_in = wr_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_SETUP: begin
            old_in  = cur_ff;
            cur_in  = DELAY_BITS'(nd_sat);
            kind_in = kind_req_ff;
            if (len_ff == '0) begin
               ratio_in = ONE_Q16;
               step_in  = '0;
               fade_in  = '0;
               state_in = ST_IDLE;
            end else begin
               ratio_in  = ratio_base;
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               step_in  = div_quotient;
               fade_in  = len_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_ff        <= '0;
         wrapped_ff   <= 1'b0;
         cur_ff       <= '0;
         old_ff       <= '0;
         ratio_ff     <= '0;
         step_ff      <= '0;
         fade_ff      <= '0;
         kind_ff      <= KIND_LINEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ff        <= wr_in;
         wrapped_ff   <= wrapped_in;
         cur_ff       <= cur_in;
         old_ff       <= old_in;
         ratio_ff     <= ratio_in;
         step_ff      <= step_in;
         fade_ff      <= fade_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      x_ff          <= x_in;
      nd_ff         <= nd_in;
      kind_req_ff   <= kind_req_in;
      len_ff        <= len_in;
      new_s_ff      <= new_s_in;
      old_s_ff      <= old_s_in;
      w_ff          <= w_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   cfvd_store #(
      .DATA_BITS (SAMPLE_BITS),
      .DEPTH     (STORE_SIZE),
      .ADDR_BITS (ADDR_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en && (type_ff == REQ_SAMPLE)),
      .wr_addr (wr_ff),
      .wr_data (x_ff),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   cfvd_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   cfvd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (len_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Channel outputs.
   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_sample = rsp_sample_ff;

endmodule

// ----- hw/rtl/cfvd_store.sv -----
// Generic single-port-write, registered-read RAM holding the sample history.
module cfvd_store #(
   parameter int DATA_BITS = 24,
   parameter int DEPTH     = 8192,
   parameter int ADDR_BITS = 13
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/cfvd_mul.sv -----
// Shared signed multiplier with a registered product.
module cfvd_mul import cfvd_pkg::*; (
   input  logic                        clock,
   input  logic signed [MUL_A_BITS-1:0] op_a,
   input  logic signed [MUL_B_BITS-1:0] op_b,
   output logic signed [PROD_BITS-1:0]  prod
);

   logic signed [PROD_BITS-1:0] prod_ff;

   // One product per cycle, registered before use.
   always_ff @(posedge clock) begin
      prod_ff <= PROD_BITS'(op_a) * PROD_BITS'(op_b);
   end

   assign prod = prod_ff;

endmodule

// ----- hw/rtl/cfvd_div.sv -----
// Restoring divider producing one quotient bit per cycle for the ratio step.
module cfvd_div import cfvd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [RATIO_BITS-1:0] dividend,
   input  logic [FADE_BITS-1:0]  divisor,
   output logic                  done,
   output logic [RATIO_BITS-1:0] quotient
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [FADE_BITS-1:0]    rem_ff, rem_in;
   logic [RATIO_BITS-1:0]   quo_ff, quo_in;
   logic [FADE_BITS-1:0]    div_ff, div_in;
   logic [FADE_BITS:0]      trial;

   // One shift-and-subtract step per cycle.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      trial   = {rem_ff, quo_ff[RATIO_BITS-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = FADE_BITS'(trial - {1'b0, div_ff});
            quo_in = {quo_ff[RATIO_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[FADE_BITS-1:0];
            quo_in = {quo_ff[RATIO_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers are reset; the datapath is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
